// ===== rtl/asht_pkg.sv =====
// Package for the averaged sample history trigger.
// Holds field widths, parameter defaults and reset constants; no dependencies.
`default_nettype none

package asht_pkg;

	// Field and state widths.
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 24;
	localparam int CNT_W    = 8;

	// Parameter defaults for the top level.
	localparam int AVG_COUNT_DEF  = 16;
	localparam int RING_DEPTH_DEF = 20;

	// Threshold after reset: no mean can exceed it.
	localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/asht_sample_if.sv =====
// Stream interface for raw converter samples.
// Depends on asht_pkg for the sample width.
`default_nettype none

interface asht_sample_if import asht_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== rtl/asht_history_if.sv =====
// Stream interface for history dump beats.
// Depends on asht_pkg for the value width.
`default_nettype none

interface asht_history_if import asht_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] history_value;
	logic                last_of_dump;

	modport source (output valid, output history_value, output last_of_dump, input ready);
	modport sink (input valid, input history_value, input last_of_dump, output ready);

endinterface

`default_nettype wire

// ===== rtl/asht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module asht_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 20
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; read data is registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/averaged_sample_history_trigger.sv =====
// Averaged sample history trigger.
//
// Samples arrive as beats on the samples channel. Each group of AVG_COUNT
// samples is summed and reduced to its truncated mean, which is written to a
// history ring of RING_DEPTH entries held in a RAM. When the mean is strictly
// greater than the threshold register, the whole ring is sent on the history
// channel, oldest entry first, ending with the new mean, which carries
// last_of_dump. The threshold is written through cfg_we and cfg_wdata.
//
// A sample that does not complete a group is accepted in the idle state. The
// sample that completes a group is accepted, then the group sum is scaled by
// a constant reciprocal to form the mean, then the ring is written. A dump
// reads RING_DEPTH entries through the single RAM read port, one beat a cycle
// while the receiver takes them. After the write, the first dump beat passes
// through a dump-state read, the registered RAM read and the output buffer.
//
// Reset clears the sum, group count, write position and the per-entry valid
// flags, so ring entries never written read as zero; the threshold resets to
// its maximum. When the receiver stalls, a two-beat output buffer fills and
// the ring reads pause; samples are taken again as soon as all reads are out.
`default_nettype none

module averaged_sample_history_trigger import asht_pkg::*; #(
	parameter int AVG_COUNT  = AVG_COUNT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	asht_sample_if.sink              samples,
	asht_history_if.source           history,
	input  wire logic                cfg_we,
	input  wire logic [SAMPLE_W-1:0] cfg_wdata
);

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);

	// Exact reciprocal for every sum below 2**SUM_W: mean = (sum * M) >> SH.
	localparam int RECIP_SH = SUM_W + $clog2(AVG_COUNT);
	localparam logic [SUM_W:0] RECIP_M = (SUM_W + 1)'(
		((64'd1 << RECIP_SH) + 64'(AVG_COUNT - 1)) / 64'(AVG_COUNT));
	localparam int PROD_W = 2 * SUM_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DUMP  = 4'b1000
	} state_t;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] pos);
		next_pos = (pos == LAST_POS) ? '0 : pos + 1'b1;
	endfunction

	state_t              state_q;
	logic [SAMPLE_W-1:0] thresh_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PW-1:0]       wpos_q;
	logic [RING_DEPTH-1:0] valid_q;

	logic [SUM_W-1:0]    grp_sum_q;
	logic [SAMPLE_W-1:0] quot_q;
	logic [PROD_W-1:0]   recip_prod;

	logic [PW-1:0]       rpos_q;
	logic [PW-1:0]       rcnt_q;

	logic                inflight_s1;
	logic                last_s1;
	logic                hit_s1;

	logic [SAMPLE_W-1:0] out_data_q [2];
	logic                out_last_q [2];
	logic [1:0]          occ_q;

	logic                in_acc;
	logic                out_pop;
	logic                issue;
	logic                issue_last;
	logic                ram_we;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] push_data;
	logic [SUM_W-1:0]    sum_full;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign out_pop       = history.valid && history.ready;
	assign sum_full      = sum_q + SUM_W'(samples.sample);
	assign recip_prod    = PROD_W'(grp_sum_q) * PROD_W'(RECIP_M);
	assign ram_we        = (state_q == ST_WRITE);

	// A read may start only if its beat is sure to find room in the buffer.
	assign issue      = (state_q == ST_DUMP) &&
		((3'(occ_q) + 3'(inflight_s1)) <= (3'd1 + 3'(out_pop)));
	assign issue_last = (rcnt_q == LAST_POS);

	// Entries never written since reset read as zero.
	assign push_data = hit_s1 ? ram_rdata : '0;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Control sequencer: accumulate, form the mean, write the ring, dump.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			cnt_q     <= '0;
			wpos_q    <= '0;
			valid_q   <= '0;
			rcnt_q    <= '0;
			rpos_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cnt_q == CNT_W'(AVG_COUNT - 1)) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							sum_q <= sum_full;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					valid_q[wpos_q] <= 1'b1;
					wpos_q          <= next_pos(wpos_q);
					rpos_q          <= next_pos(wpos_q);
					rcnt_q          <= '0;
					if (quot_q > thresh_q) begin
						state_q <= ST_DUMP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (issue) begin
						rpos_q <= next_pos(rpos_q);
						rcnt_q <= rcnt_q + 1'b1;
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Mean datapath: hold the group sum, then scale it by the reciprocal.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			grp_sum_q <= sum_full;
		end
		if (state_q == ST_DIV) begin
			quot_q <= recip_prod[RECIP_SH +: SAMPLE_W];
		end
	end

	// History ring storage.
	asht_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wpos_q),
		.wdata (quot_q),
		.re    (issue),
		.raddr (rpos_q),
		.rdata (ram_rdata)
	);

	// Read tracking: marks the cycle in which read data returns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_s1 <= 1'b0;
		end else begin
			inflight_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= issue_last;
			hit_s1  <= valid_q[rpos_q];
		end
	end

	// Two-beat output buffer; slot 0 is the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			if (inflight_s1 && !out_pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (!inflight_s1 && out_pop) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop) begin
			if (inflight_s1 && occ_q == 2'd1) begin
				out_data_q[0] <= push_data;
				out_last_q[0] <= last_s1;
			end else begin
				out_data_q[0] <= out_data_q[1];
				out_last_q[0] <= out_last_q[1];
				if (inflight_s1) begin
					out_data_q[1] <= push_data;
					out_last_q[1] <= last_s1;
				end
			end
		end else if (inflight_s1) begin
			if (occ_q == 2'd0) begin
				out_data_q[0] <= push_data;
				out_last_q[0] <= last_s1;
			end else begin
				out_data_q[1] <= push_data;
				out_last_q[1] <= last_s1;
			end
		end
	end

	assign history.valid         = (occ_q != 2'd0);
	assign history.history_value = out_data_q[0];
	assign history.last_of_dump  = out_last_q[0];

	// The buffer never holds more than two beats.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 2'd2)
		else $error("output buffer overfilled");

	// Read data returns only for reads started during a dump.
	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_s1 |-> $past(state_q == ST_DUMP))
		else $error("read data without a dump read");

	// The ring write always follows the cycle that forms the mean.
	a_write_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> $past(state_q == ST_DIV))
		else $error("ring write without a complete mean");

	// The final ring read ends the dump.
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && issue_last) |=> (state_q == ST_IDLE))
		else $error("dump did not end after its last read");

endmodule

`default_nettype wire
